@@ hdl/vocp_pkg.sv @@
// Package for the VOC stream parser: result kinds, status codes, field widths
// and the header signature table. No dependencies.
`timescale 1ns / 1ps
package vocp_pkg;

  localparam int unsigned RunW  = 25;
  localparam int unsigned RateW = 20;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_SILENCE = 2'd1,
    KIND_FINISHED = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0,
    ST_SIGNATURE = 4'd1,
    ST_OFFSET = 4'd2,
    ST_VERSION = 4'd3,
    ST_ID = 4'd4,
    ST_TRUNCATED = 4'd5,
    ST_UNHANDLED = 4'd6,
    ST_RATE_CHANGED = 4'd7,
    ST_PACKING = 4'd8
  } status_t;

  // Back-end commands carried through the queue.
  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_NOTICE = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_SETRATE = 3'd3,
    CMD_SILENCE = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data;    // sample byte or time constant
    logic [15:0] count;   // silence count
    status_t     status;
  } vocp_cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       sample;
    logic [RunW-1:0]  run_length;
    logic [RateW-1:0] rate_hz;
    status_t          status;
    logic [31:0]      total_samples;
    logic             last;
  } vocp_res_t;

  function automatic logic [7:0] sig_byte(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'h43;  5'd1: r = 8'h72;  5'd2: r = 8'h65;  5'd3: r = 8'h61;
      5'd4: r = 8'h74;  5'd5: r = 8'h69;  5'd6: r = 8'h76;  5'd7: r = 8'h65;
      5'd8: r = 8'h20;  5'd9: r = 8'h56;  5'd10: r = 8'h6F; 5'd11: r = 8'h69;
      5'd12: r = 8'h63; 5'd13: r = 8'h65; 5'd14: r = 8'h20; 5'd15: r = 8'h46;
      5'd16: r = 8'h69; 5'd17: r = 8'h6C; 5'd18: r = 8'h65; 5'd19: r = 8'h1A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/vocp_front.sv @@
// Front end of the VOC parser: header checks and block framing, one byte per
// cycle while the queue has room, emitting commands into it. Uses vocp_pkg.
`timescale 1ns / 1ps
module vocp_front import vocp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output vocp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    PH_HEADER  = 10'b0000000001,
    PH_CODE    = 10'b0000000010,
    PH_LEN     = 10'b0000000100,
    PH_TC      = 10'b0000001000,
    PH_PACK    = 10'b0000010000,
    PH_SAMPLES = 10'b0000100000,
    PH_SKIP    = 10'b0001000000,
    PH_SIL_LEN = 10'b0010000000,
    PH_SIL_TC  = 10'b0100000000,
    PH_DONE    = 10'b1000000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  byte_index, byte_index_next;
  logic [15:0] ver, ver_next;
  logic        f_sig, f_sig_next, f_off, f_off_next, f_ver, f_ver_next;
  logic        f_id, f_id_next;
  logic [7:0]  block_code, block_code_next, tc, tc_next;
  logic [23:0] remaining, remaining_next;
  logic [15:0] sil, sil_next;
  logic [15:0] idv;
  logic [7:0]  want;
  logic [23:0] rem2;
  logic        emit;
  vocp_cmd_t   c;

  // The front stalls whenever the queue is full, whether or not the byte
  // would give a command.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && emit;
  assign cmd       = c;
  assign idv  = 16'h1234 + ~ver;
  assign rem2 = (remaining >= 24'd2) ? remaining - 24'd2 : 24'd0;

  always_comb begin
    phase_next = phase;
    byte_index_next = byte_index;
    ver_next = ver;
    f_sig_next = f_sig; f_off_next = f_off; f_ver_next = f_ver; f_id_next = f_id;
    block_code_next = block_code;
    tc_next = tc;
    remaining_next = remaining;
    sil_next = sil;
    emit = 1'b0;
    want = 8'd0;
    c = '{cmd: CMD_FINISH, data: 8'd0, count: 16'd0, status: ST_OK};
    if (phase == PH_DONE) begin
      emit = 1'b0;
    end else if (end_of_input) begin
      emit = 1'b1;
      c.status = (phase == PH_CODE) ? ST_OK : ST_TRUNCATED;
      phase_next = PH_DONE;
    end else begin
      case (phase)
        PH_HEADER: begin
          byte_index_next = byte_index + 5'd1;
          if (byte_index < 5'd20) begin
            if (in_byte != sig_byte(byte_index)) f_sig_next = 1'b1;
            if (byte_index == 5'd19 && f_sig_next) begin
              emit = 1'b1; c.status = ST_SIGNATURE; phase_next = PH_DONE;
            end
          end else if (byte_index == 5'd20) begin
            if (in_byte != 8'd26) f_off_next = 1'b1;
          end else if (byte_index == 5'd21) begin
            if (in_byte != 8'd0) f_off_next = 1'b1;
          end else if (byte_index == 5'd22) begin
            ver_next = {8'd0, in_byte};
          end else if (byte_index == 5'd23) begin
            ver_next = {in_byte, ver[7:0]};
            if (!(ver_next == 16'h010A || ver_next == 16'h0114 || ver_next == 16'h0100))
              f_ver_next = 1'b1;
          end else begin
            want = (byte_index == 5'd24) ? idv[7:0] : idv[15:8];
            if (in_byte != want) f_id_next = 1'b1;
            if (byte_index != 5'd24) begin
              byte_index_next = 5'd0;
              if (f_off) begin
                emit = 1'b1; c.status = ST_OFFSET; phase_next = PH_DONE;
              end else if (f_ver) begin
                emit = 1'b1; c.status = ST_VERSION; phase_next = PH_DONE;
              end else if (f_id_next) begin
                emit = 1'b1; c.status = ST_ID; phase_next = PH_DONE;
              end else begin
                phase_next = PH_CODE;
              end
            end
          end
        end
        PH_CODE: begin
          if (in_byte == 8'd0) begin
            emit = 1'b1; phase_next = PH_DONE;
          end else begin
            block_code_next = in_byte;
            byte_index_next = 5'd0;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          case (byte_index[1:0])
            2'd0: remaining_next = {16'd0, in_byte};
            2'd1: remaining_next = {8'd0, in_byte, remaining[7:0]};
            default: remaining_next = {in_byte, remaining[15:0]};
          endcase
          byte_index_next = byte_index + 5'd1;
          if (byte_index[1:0] == 2'd2) begin
            byte_index_next = 5'd0;
            if (block_code == 8'd1) begin
              phase_next = PH_TC;
            end else if (block_code == 8'd3) begin
              phase_next = PH_SIL_LEN;
            end else begin
              emit = 1'b1; c.status = ST_UNHANDLED; phase_next = PH_DONE;
            end
          end
        end
        PH_TC: begin
          tc_next = in_byte;
          phase_next = PH_PACK;
        end
        PH_PACK: begin
          // The back end works out the rate and decides on any notice.
          emit = 1'b1;
          c.cmd = CMD_SETRATE;
          c.data = tc;
          c.status = (in_byte != 8'd0) ? ST_PACKING : ST_OK;
          remaining_next = rem2;
          if (rem2 == 24'd0) phase_next = PH_CODE;
          else phase_next = (in_byte != 8'd0) ? PH_SKIP : PH_SAMPLES;
        end
        PH_SAMPLES: begin
          emit = 1'b1;
          c.cmd = CMD_SAMPLE;
          c.data = in_byte;
          remaining_next = remaining - 24'd1;
          if (remaining == 24'd1) phase_next = PH_CODE;
        end
        PH_SKIP: begin
          remaining_next = remaining - 24'd1;
          if (remaining == 24'd1) phase_next = PH_CODE;
        end
        PH_SIL_LEN: begin
          if (byte_index[0]) begin
            sil_next = {in_byte, sil[7:0]};
            byte_index_next = 5'd0;
            phase_next = PH_SIL_TC;
          end else begin
            sil_next = {8'd0, in_byte};
            byte_index_next = 5'd1;
          end
        end
        PH_SIL_TC: begin
          emit = 1'b1;
          c.cmd = CMD_SILENCE;
          c.data = in_byte;
          c.count = sil;
          phase_next = PH_CODE;
        end
        default: phase_next = PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_index <= 5'd0;
      f_sig <= 1'b0; f_off <= 1'b0; f_ver <= 1'b0; f_id <= 1'b0;
      ver <= 16'd0;
      remaining <= 24'd0;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
      byte_index <= byte_index_next;
      f_sig <= f_sig_next; f_off <= f_off_next; f_ver <= f_ver_next; f_id <= f_id_next;
      ver <= ver_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      block_code <= block_code_next;
      tc <= tc_next;
      sil <= sil_next;
    end
  end

endmodule

@@ hdl/vocp_fifo.sv @@
// Short command queue between the front and back ends of the VOC parser.
// Four entries, registered. Depends on vocp_pkg.
`timescale 1ns / 1ps
module vocp_fifo import vocp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  vocp_cmd_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output vocp_cmd_t rd_data
);

  vocp_cmd_t  mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != 3'd4);
  assign rd_valid = (cnt != 3'd0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0; rp <= 2'd0; cnt <= 3'd0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, wr} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

endmodule

@@ hdl/vocp_div.sv @@
// Restoring divider for the VOC parser back end: 36-bit dividend by 20-bit
// divisor, one quotient bit per cycle. Depends on vocp_pkg.
`timescale 1ns / 1ps
module vocp_div import vocp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [35:0] dividend,
  input  logic [19:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [35:0] quotient
);

  logic [35:0] q;
  logic [20:0] r;
  logic [19:0] d;
  logic [5:0]  n;
  logic [20:0] trial;

  assign trial = {r[19:0], q[35]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; n <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1; n <= 6'd36;
      end else if (busy) begin
        n <= n - 6'd1;
        if (n == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q <= dividend; r <= 21'd0; d <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= trial - {1'b0, d};
        q <= {q[34:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[34:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/vocp_back.sv @@
// Back end of the VOC parser: rate conversion, silence runs, totals and the
// output register. Depends on vocp_pkg and vocp_div.
`timescale 1ns / 1ps
module vocp_back import vocp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  vocp_cmd_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output vocp_res_t res
);

  typedef enum logic [3:0] {
    BS_IDLE = 4'b0001,
    BS_RATE = 4'b0010,
    BS_MUL  = 4'b0100,
    BS_SIL  = 4'b1000
  } bstate_t;

  bstate_t          bs;
  logic [RateW-1:0] cur_rate;
  logic [31:0]      total;
  logic [35:0]      prod;
  logic [7:0]       tc;
  logic [15:0]      count;
  status_t          pstat;
  cmd_t             pcmd;
  logic             div_start, div_busy, div_done;
  logic [35:0]      div_dvd, quo;
  logic [19:0]      div_dvs;
  logic [RateW-1:0] nr;
  logic             out_free, take;
  logic [35:0]      run_full;
  logic [RunW-1:0]  run;
  logic [32:0]      tsum;
  logic [31:0]      tsat;
  logic             special;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (bs == BS_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign special   = (tc == 8'hA5) || (tc == 8'hA6) || (tc == 8'hD2) || (tc == 8'hD3);

  assign div_dvd = (bs == BS_MUL) ? prod : 36'd1000000;
  assign div_dvs = (bs == BS_MUL) ? cur_rate : {11'd0, 9'd256 - {1'b0, tc}};
  // The fixed-rate time constants need no rate division.
  assign div_start = ((bs == BS_RATE && !special) || (bs == BS_MUL)) && !div_busy
                     && !div_done;

  always_comb begin
    if (tc == 8'hA5 || tc == 8'hA6) nr = 20'd11025;
    else if (tc == 8'hD2 || tc == 8'hD3) nr = 20'd22050;
    else nr = quo[RateW-1:0];
  end

  assign run_full = quo + 36'd1;
  assign run = (cur_rate == 20'd0) ? {9'd0, count}
             : (run_full > 36'h1FFFFFF) ? {RunW{1'b1}} : run_full[RunW-1:0];
  assign tsum = {1'b0, total} + {8'd0, run};
  assign tsat = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bs <= BS_IDLE;
      cur_rate <= '0;
      total <= 32'd0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready &&
          !(take && (cmd.cmd == CMD_SAMPLE || cmd.cmd == CMD_FINISH)))
        res_valid <= 1'b0;
      case (bs)
        BS_IDLE: begin
          if (take) begin
            case (cmd.cmd)
              CMD_SAMPLE: begin
                res_valid <= 1'b1;
                total <= (total == 32'hFFFFFFFF) ? total : total + 32'd1;
                res <= '{kind: KIND_SAMPLE, sample: cmd.data, run_length: '0,
                         rate_hz: cur_rate, status: ST_OK,
                         total_samples: (total == 32'hFFFFFFFF) ? total : total + 32'd1,
                         last: 1'b0};
              end
              CMD_FINISH: begin
                res_valid <= 1'b1;
                res <= '{kind: KIND_FINISHED, sample: 8'd0, run_length: '0,
                         rate_hz: cur_rate, status: cmd.status, total_samples: total,
                         last: 1'b1};
              end
              CMD_SETRATE: bs <= BS_RATE;
              CMD_SILENCE: bs <= (cur_rate == 20'd0) ? BS_SIL : BS_RATE;
              default: bs <= BS_IDLE;
            endcase
          end
        end
        BS_RATE: begin
          if (div_done || special) begin
            if (pcmd == CMD_SETRATE) begin
              cur_rate <= nr;
              bs <= BS_IDLE;
              if (pstat == ST_PACKING || (cur_rate != 20'd0 && cur_rate != nr)) begin
                res_valid <= 1'b1;
                res <= '{kind: KIND_SILENCE, sample: 8'h80, run_length: '0, rate_hz: nr,
                         status: (pstat == ST_PACKING) ? ST_PACKING : ST_RATE_CHANGED,
                         total_samples: total, last: 1'b0};
              end
            end else begin
              bs <= BS_MUL;
            end
          end
        end
        BS_MUL: if (div_done) bs <= BS_SIL;
        BS_SIL: begin
          bs <= BS_IDLE;
          res_valid <= 1'b1;
          total <= tsat;
          res <= '{kind: KIND_SILENCE, sample: 8'h80, run_length: run, rate_hz: cur_rate,
                   status: ST_OK, total_samples: tsat, last: 1'b0};
        end
        default: bs <= BS_IDLE;
      endcase
    end
  end

  // Payload of the command in progress; the multiply is registered before it
  // feeds the divider.
  always_ff @(posedge clk) begin
    if (take) begin
      tc <= cmd.data; count <= cmd.count; pstat <= cmd.status; pcmd <= cmd.cmd;
    end
    if (bs == BS_RATE && (div_done || special)) begin
      prod <= nr * count;
    end
  end

  vocp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .busy(div_busy), .done(div_done), .quotient(quo)
  );

endmodule

@@ hdl/voc_audio_stream_parser_top.sv @@
// VOC audio stream parser, top level. Joins the front end, command queue and
// back end. Depends on vocp_pkg, vocp_front, vocp_fifo and vocp_back.
//
// Usage: file bytes enter on the s_axis channel, one per request; tuser[0]
// marks the end of the stream (the byte is then ignored). Results leave on
// m_axis with the result kind in tuser and tlast on the final result of the file.
// Header and framing bytes are taken one per cycle; data bytes become samples
// through the queue and the output register, one byte per cycle while the queue
// has room. A data block header waits in the back end for the rate division,
// and a silence block for the rate division, then the run division, both on the
// single shared serial divider; the fixed-rate time constants skip the rate
// division; a silence block before any rate is set skips both. The four-entry
// queue absorbs the wait so the front keeps taking bytes until it fills.
// Reset clears all parse state and returns to the header. When the receiver
// stalls, the output register holds, the queue fills, and s_axis_tready falls.
// After the finished result no further results appear until reset.
`timescale 1ns / 1ps
module voc_audio_stream_parser_top import vocp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // sample, run_length, rate_hz, status, total_samples
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  vocp_cmd_t f_cmd, q_cmd;
  logic      f_valid, f_ready, q_valid, q_ready;
  vocp_res_t res;

  vocp_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .end_of_input(s_axis_tuser),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  vocp_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  vocp_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {7'd0, res.total_samples, res.status, res.rate_hz,
                         res.run_length, res.sample};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_FINISHED)))
    else $error("tlast disagrees with result kind");

  a_sample_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_SAMPLE) |-> (m_axis_tdata[32:8] == '0))
    else $error("sample result carries a run length");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=>
      (!m_axis_tvalid || m_axis_tdata[88:57] >= $past(m_axis_tdata[88:57])))
    else $error("sample total went backwards");

endmodule
